### rtl/planar_pose_frame_transform_macros.svh
// Assertion macros shared by the pose transform RTL.
`ifndef PLANAR_POSE_FRAME_TRANSFORM_MACROS_SVH
`define PLANAR_POSE_FRAME_TRANSFORM_MACROS_SVH

`ifndef SYNTHESIS
// Clocked property that is switched off while reset is high.
`define PPFT_ASSERT(name, clock, reset, prop, msg) \
  name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Clocked property that is also checked while reset is high.
`define PPFT_ASSERT_ALWAYS(name, clock, prop, msg) \
  name: assert property (@(posedge clock) prop) else $error(msg);
`else
`define PPFT_ASSERT(name, clock, reset, prop, msg)
`define PPFT_ASSERT_ALWAYS(name, clock, prop, msg)
`endif

`endif

### rtl/ppft_pkg.sv
// Types, constants and the sine table generator of the planar pose transform.
`default_nettype none

package ppft_pkg;

  localparam int SINE_TABLE_BITS_DEF = 10;
  localparam int TRIG_FRAC_BITS_DEF  = 16;

  localparam int POS_W      = 32;
  localparam int ANG_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROTATION = 2'd2;

  localparam logic OP_TO_WORLD   = 1'b0;
  localparam logic OP_TO_VEHICLE = 1'b1;

  // pi/2 in Q30
  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

  typedef struct packed {
    logic                    op;
    logic signed [POS_W-1:0] pose_x;
    logic signed [POS_W-1:0] pose_y;
    logic signed [ANG_W-1:0] pose_heading;
  } ppft_req_t;

  typedef struct packed {
    logic signed [POS_W-1:0] out_x;
    logic signed [POS_W-1:0] out_y;
    logic signed [ANG_W-1:0] out_heading;
    logic                    saturated;
  } ppft_res_t;

  // Truncating unsigned quotient by shift and subtract, for elaboration only.
  // The divisor is small, so the partial remainder never overflows.
  function automatic longint unsigned div_trunc(longint unsigned num, longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // One quarter-wave sine entry, evaluated at elaboration time only. The
  // Taylor series runs to x^21 in Q30 with truncating steps, then the sum
  // is rounded half up to fbits fraction bits.
  function automatic logic [31:0] sine_entry(int unsigned idx, int unsigned tbits,
                                             int unsigned fbits);
    longint unsigned x;
    longint unsigned term;
    longint unsigned half;
    longint unsigned divisor;
    longint          sum;
    x    = (PI_HALF_Q30 * 64'(idx)) >> tbits;
    term = x;
    sum  = $signed(x);
    half = 64'd1 << (29 - fbits);
    for (int k = 1; k <= 10; k++) begin
      term    = (term * x) >> 30;
      term    = (term * x) >> 30;
      divisor = 64'((2 * k) * (2 * k + 1));
      term    = div_trunc(term, divisor);
      if (k[0]) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    return 32'(($unsigned(sum) + half) >> (30 - fbits));
  endfunction

endpackage

`default_nettype wire

### rtl/planar_pose_frame_transform.sv
// Planar pose frame transform: six-stage pipeline, one request per clock outside reset.
`default_nettype none

`include "planar_pose_frame_transform_macros.svh"

// Maps a planar pose between the vehicle frame and the world frame with the
// calibration held in three registers (offset_x, offset_y, rotation). A
// request is taken at every rising edge where start is high and busy is low;
// busy is high only while rst is asserted, so one request may enter on every
// clock cycle. Each request gives exactly one result, presented on res for a
// single cycle with done high. The pipeline has six register stages (request
// and angle decode, sine table read, the four 33-by-(TRIG_FRAC_BITS+2) bit
// products, the cross sums, the rounding shift, and the offset add with
// saturation). The receiver has no way to hold a result back: it must take
// the result in the cycle it is shown, and results come out in request
// order. The quarter-wave sine table has 2^SINE_TABLE_BITS + 1 entries and is
// built as a constant when the design is elaborated; angle bits below the
// table index are truncated, without interpolation. Headings wrap modulo a
// full turn, so a heading of plus pi is reported as minus pi. The
// configuration registers must only be written while no request is in the
// pipeline; a write takes effect at the edge on which cfg_we is high, and an
// index beyond the last register is ignored.
module planar_pose_frame_transform #(
  parameter int SINE_TABLE_BITS = ppft_pkg::SINE_TABLE_BITS_DEF,
  parameter int TRIG_FRAC_BITS  = ppft_pkg::TRIG_FRAC_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output      logic                                busy,
  input  wire ppft_pkg::ppft_req_t                 req,
  output      logic                                done,
  output      ppft_pkg::ppft_res_t                 res,
  input  wire logic                                cfg_we,
  input  wire logic [ppft_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [ppft_pkg::CFG_DATA_W-1:0]     cfg_data
);

  import ppft_pkg::*;

  // Table geometry and the widths of the datapath.
  localparam int SINE_LEN = (1 << SINE_TABLE_BITS) + 1;
  localparam int IDX_W    = SINE_TABLE_BITS + 1;
  localparam int TBL_W    = TRIG_FRAC_BITS + 1;
  localparam int TRIG_W   = TRIG_FRAC_BITS + 2;
  localparam int DIFF_W   = POS_W + 1;
  localparam int PROD_W   = DIFF_W + TRIG_W;
  localparam int SUM_W    = PROD_W + 1;
  localparam int SHR_W    = SUM_W - TRIG_FRAC_BITS;
  localparam int FIN_W    = SHR_W + 1;
  localparam int LATENCY  = 6;

  localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (TRIG_FRAC_BITS - 1);
  localparam logic signed [FIN_W-1:0] POS_MAX    = FIN_W'(2147483647);
  localparam logic signed [FIN_W-1:0] POS_MIN    = ~POS_MAX;
  localparam logic [ANG_W-1:0]        QUARTER    = ANG_W'(16384);

  typedef logic [TBL_W-1:0] sine_tbl_t [SINE_LEN];

  function automatic sine_tbl_t build_sine();
    sine_tbl_t tbl;
    for (int i = 0; i < SINE_LEN; i++) begin
      tbl[i] = TBL_W'(sine_entry(i, SINE_TABLE_BITS, TRIG_FRAC_BITS));
    end
    return tbl;
  endfunction

  localparam sine_tbl_t SINE_TBL = build_sine();

  // Table address of a binary angle: the top two bits give the quadrant,
  // odd quadrants read the table mirrored, the lower half-turn negates.
  typedef struct packed {
    logic             neg;
    logic [IDX_W-1:0] addr;
  } trig_addr_t;

  function automatic trig_addr_t trig_addr(logic [ANG_W-1:0] a);
    trig_addr_t                 t;
    logic [SINE_TABLE_BITS-1:0] raw;
    raw   = a[ANG_W-3 -: SINE_TABLE_BITS];
    t.neg = a[ANG_W-1];
    if (a[ANG_W-2]) begin
      t.addr = IDX_W'(SINE_LEN - 1) - IDX_W'(raw);
    end else begin
      t.addr = IDX_W'(raw);
    end
    return t;
  endfunction

  // Calibration registers.
  logic signed [POS_W-1:0] offset_x;
  logic signed [POS_W-1:0] offset_y;
  logic        [ANG_W-1:0] rotation;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x <= '0;
      offset_y <= '0;
      rotation <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OFFSET_X: offset_x <= $signed(cfg_data[POS_W-1:0]);
        REG_OFFSET_Y: offset_y <= $signed(cfg_data[POS_W-1:0]);
        REG_ROTATION: rotation <= cfg_data[ANG_W-1:0];
        default:      ;
      endcase
    end
  end

  assign busy = rst;

  logic accept;
  assign accept = start && !busy;

  // Stage 1: heading, rotation angle and table addresses; the inverse
  // transform takes the offset away here, before rotating.
  logic [ANG_W-1:0]         ang_next;
  logic [ANG_W-1:0]         head_next;
  logic signed [DIFF_W-1:0] x_next;
  logic signed [DIFF_W-1:0] y_next;
  logic signed [DIFF_W-1:0] px_ext;
  logic signed [DIFF_W-1:0] py_ext;

  always_comb begin
    px_ext = $signed({req.pose_x[POS_W-1], req.pose_x});
    py_ext = $signed({req.pose_y[POS_W-1], req.pose_y});
    if (req.op == OP_TO_VEHICLE) begin
      ang_next  = ANG_W'(0) - rotation;
      head_next = req.pose_heading - rotation;
      x_next    = px_ext - $signed({offset_x[POS_W-1], offset_x});
      y_next    = py_ext - $signed({offset_y[POS_W-1], offset_y});
    end else begin
      ang_next  = rotation;
      head_next = req.pose_heading + rotation;
      x_next    = px_ext;
      y_next    = py_ext;
    end
  end

  logic                     v1;
  logic                     op1;
  logic [ANG_W-1:0]         head1;
  logic signed [DIFF_W-1:0] x1;
  logic signed [DIFF_W-1:0] y1;
  trig_addr_t               sin_a1;
  trig_addr_t               cos_a1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept;
    end
    op1    <= req.op;
    head1  <= head_next;
    x1     <= x_next;
    y1     <= y_next;
    sin_a1 <= trig_addr(ang_next);
    cos_a1 <= trig_addr(ang_next + QUARTER);
  end

  // Stage 2: sine and cosine from the quarter-wave table.
  logic signed [TRIG_W-1:0] sin_mag;
  logic signed [TRIG_W-1:0] cos_mag;

  assign sin_mag = $signed({1'b0, SINE_TBL[sin_a1.addr]});
  assign cos_mag = $signed({1'b0, SINE_TBL[cos_a1.addr]});

  logic                     v2;
  logic                     op2;
  logic [ANG_W-1:0]         head2;
  logic signed [DIFF_W-1:0] x2;
  logic signed [DIFF_W-1:0] y2;
  logic signed [TRIG_W-1:0] s2;
  logic signed [TRIG_W-1:0] c2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    op2   <= op1;
    head2 <= head1;
    x2    <= x1;
    y2    <= y1;
    s2    <= sin_a1.neg ? -sin_mag : sin_mag;
    c2    <= cos_a1.neg ? -cos_mag : cos_mag;
  end

  // Stage 3: the four products, each exact.
  logic                     v3;
  logic                     op3;
  logic [ANG_W-1:0]         head3;
  logic signed [PROD_W-1:0] cx3;
  logic signed [PROD_W-1:0] sy3;
  logic signed [PROD_W-1:0] sx3;
  logic signed [PROD_W-1:0] cy3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    op3   <= op2;
    head3 <= head2;
    cx3   <= c2 * x2;
    sy3   <= s2 * y2;
    sx3   <= s2 * x2;
    cy3   <= c2 * y2;
  end

  // Stage 4: cross sums of the rotation.
  logic                    v4;
  logic                    op4;
  logic [ANG_W-1:0]        head4;
  logic signed [SUM_W-1:0] rx4;
  logic signed [SUM_W-1:0] ry4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    op4   <= op3;
    head4 <= head3;
    rx4   <= SUM_W'(cx3) - SUM_W'(sy3);
    ry4   <= SUM_W'(sx3) + SUM_W'(cy3);
  end

  // Stage 5: round half up, ties towards plus infinity.
  logic signed [SUM_W-1:0] rx_rnd;
  logic signed [SUM_W-1:0] ry_rnd;

  assign rx_rnd = rx4 + ROUND_HALF;
  assign ry_rnd = ry4 + ROUND_HALF;

  logic                    v5;
  logic                    op5;
  logic [ANG_W-1:0]        head5;
  logic signed [SHR_W-1:0] rx5;
  logic signed [SHR_W-1:0] ry5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
    op5   <= op4;
    head5 <= head4;
    rx5   <= $signed(rx_rnd[SUM_W-1:TRIG_FRAC_BITS]);
    ry5   <= $signed(ry_rnd[SUM_W-1:TRIG_FRAC_BITS]);
  end

  // Stage 6: the forward transform adds the offset, then both positions
  // are clipped to the 32-bit range.
  logic signed [FIN_W-1:0] fx;
  logic signed [FIN_W-1:0] fy;
  ppft_res_t               res_next;
  logic                    sat_x;
  logic                    sat_y;

  always_comb begin
    fx = FIN_W'(rx5);
    fy = FIN_W'(ry5);
    if (op5 == OP_TO_WORLD) begin
      fx = fx + FIN_W'(offset_x);
      fy = fy + FIN_W'(offset_y);
    end
    sat_x = 1'b1;
    sat_y = 1'b1;
    if (fx > POS_MAX) begin
      res_next.out_x = POS_MAX[POS_W-1:0];
    end else if (fx < POS_MIN) begin
      res_next.out_x = POS_MIN[POS_W-1:0];
    end else begin
      res_next.out_x = fx[POS_W-1:0];
      sat_x          = 1'b0;
    end
    if (fy > POS_MAX) begin
      res_next.out_y = POS_MAX[POS_W-1:0];
    end else if (fy < POS_MIN) begin
      res_next.out_y = POS_MIN[POS_W-1:0];
    end else begin
      res_next.out_y = fy[POS_W-1:0];
      sat_y          = 1'b0;
    end
    res_next.out_heading = head5;
    res_next.saturated   = sat_x || sat_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v5;
    end
    res <= res_next;
  end

  // Every request taken comes out as exactly one result, and nothing else does.
  `PPFT_ASSERT(a_req_to_res, clk, rst, accept |-> ##LATENCY done, "request did not yield a result")
  `PPFT_ASSERT(a_res_from_req, clk, rst, done |-> $past(accept, LATENCY), "result without request")
  // The heading is the request heading turned by the calibration angle.
  `PPFT_ASSERT(a_heading, clk, rst, done |-> (res.out_heading == ($past(req.op, LATENCY) ? ANG_W'($past(req.pose_heading, LATENCY) - rotation) : ANG_W'($past(req.pose_heading, LATENCY) + rotation))), "heading mismatch")
  // A saturated result has at least one position pinned at a limit.
  `PPFT_ASSERT(a_sat_limit, clk, rst, (done && res.saturated) |-> (res.out_x == POS_MAX[POS_W-1:0] || res.out_x == POS_MIN[POS_W-1:0] || res.out_y == POS_MAX[POS_W-1:0] || res.out_y == POS_MIN[POS_W-1:0]), "saturation flag without a clipped position")
  // Reset clears the result strobe.
  `PPFT_ASSERT_ALWAYS(a_rst_done, clk, rst |=> !done, "result strobe survived reset")

endmodule

`default_nettype wire
